### rtl/mirror_padded_window_filter_core_assert.svh
// Assertion macros used by the window filter back end.
`ifndef MIRROR_PADDED_WINDOW_FILTER_CORE_ASSERT_SVH
`define MIRROR_PADDED_WINDOW_FILTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MPWF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mpwf assertion failed");
`define MPWF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mpwf assertion failed");
`else
`define MPWF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MPWF_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/mpwf_pkg.sv
// Shared types and constants of the window filter.
package mpwf_pkg;

  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_RADIUS_DEF  = 2;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam int COL_W  = 11;
  localparam int ROW_W  = 13;
  localparam int SLOT_W = 3;
  localparam int CNT_W  = 2;
  localparam int RAD_W  = 2;
  localparam int QDEPTH = 4;

  localparam int MIN_SIDE   = 5;
  localparam int MAX_HEIGHT = 4096;

  // floor(x / 9) and floor(x / 25) for x < 8192 via reciprocal multiply
  localparam int RECIP_SHIFT = 18;
  localparam int RECIP_W     = 15;
  localparam logic [RECIP_W-1:0] RECIP_R1 = 15'd29128;
  localparam logic [RECIP_W-1:0] RECIP_R2 = 15'd10486;

  localparam logic              MODE_RST   = 1'b0;
  localparam logic [RAD_W-1:0]  RADIUS_RST = 2'd1;
  localparam logic [COL_W-1:0]  WIDTH_RST  = 11'd768;
  localparam logic [ROW_W-1:0]  HEIGHT_RST = 13'd512;
  localparam logic [63:0]       WNEAR_RST  = 64'd397459147319552190;
  localparam logic [31:0]       WFAR_RST   = 32'd12518232;

  typedef enum logic [2:0] {
    CFG_MODE   = 3'd0,
    CFG_RADIUS = 3'd1,
    CFG_WIDTH  = 3'd2,
    CFG_HEIGHT = 3'd3,
    CFG_WNEAR  = 3'd4,
    CFG_WFAR   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic [COL_W-1:0] width;
    logic [ROW_W-1:0] height;
  } geo_t;

  typedef struct packed {
    logic        mode;
    logic [63:0] wnear;
    logic [31:0] wfar;
  } coef_t;

  typedef struct packed {
    logic              wr;
    logic [7:0]        pix;
    logic [SLOT_W-1:0] slot;
    logic [COL_W-1:0]  col;
    logic [CNT_W-1:0]  cnt;
  } q_entry_t;

endpackage

### rtl/mpwf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mpwf_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/mpwf_queue.sv
// Short request queue between the front and back ends.
module mpwf_queue import mpwf_pkg::*; #(
  parameter int DEPTH = QDEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t din,
  output logic     full,
  input  logic     pop,
  output q_entry_t dout,
  output logic     empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  q_entry_t        mem_r [DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [NW-1:0]   num_r;

  assign full  = (num_r == NW'(DEPTH));
  assign empty = (num_r == '0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      num_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        num_r <= num_r + 1'b1;
      end else if (pop && !push) begin
        num_r <= num_r - 1'b1;
      end
    end
  end

endmodule

### rtl/mpwf_front.sv
// Front end: tracks the input position and classifies each request.
module mpwf_front import mpwf_pkg::*; #(
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_cmd,
  input  logic [7:0] in_pixel_in,
  input  geo_t     geo,
  input  logic     restart,
  output logic     q_push,
  output q_entry_t q_data,
  input  logic     q_full
);

  localparam int LINE_ROWS = 2 * MAX_RADIUS + 1;

  logic [ROW_W-1:0]  in_row_r;
  logic [COL_W-1:0]  in_col_r;
  logic [SLOT_W-1:0] in_slot_r;

  logic             take, row_ok, drop, out_ok, last_col, done;
  logic [CNT_W-1:0] cnt;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign row_ok   = in_row_r < geo.height;
  assign drop     = row_ok && in_cmd;       // drain before the frame is complete
  assign out_ok   = (in_row_r >= ROW_W'(geo.rad)) && (in_col_r >= COL_W'(geo.rad));
  assign last_col = in_col_r == (geo.width - COL_W'(1));
  assign done     = last_col &&
                    (in_row_r == (geo.height - ROW_W'(1) + ROW_W'(geo.rad)));

  always_comb begin
    if (!out_ok) begin
      cnt = '0;
    end else if (last_col) begin
      cnt = CNT_W'(geo.rad) + CNT_W'(1);
    end else begin
      cnt = CNT_W'(1);
    end
  end

  assign q_push      = take && !drop && (row_ok || (cnt != '0));
  assign q_data.wr   = row_ok;
  assign q_data.pix  = in_pixel_in;
  assign q_data.slot = in_slot_r;
  assign q_data.col  = in_col_r;
  assign q_data.cnt  = cnt;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      in_row_r  <= '0;
      in_col_r  <= '0;
      in_slot_r <= '0;
    end else if (take && !drop) begin
      if (done) begin
        in_row_r  <= '0;
        in_col_r  <= '0;
        in_slot_r <= '0;
      end else if (last_col) begin
        in_col_r  <= '0;
        in_row_r  <= in_row_r + 1'b1;
        in_slot_r <= (in_slot_r == SLOT_W'(LINE_ROWS - 1)) ? '0 : in_slot_r + 1'b1;
      end else begin
        in_col_r <= in_col_r + 1'b1;
      end
    end
  end

endmodule

### rtl/mpwf_back.sv
// Back end: line store writes, window accumulation and result output.
`include "mirror_padded_window_filter_core_assert.svh"
module mpwf_back import mpwf_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_RADIUS  = MAX_RADIUS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  geo_t       geo,
  input  coef_t      coef,
  input  logic       restart,
  input  logic       q_empty,
  input  q_entry_t   q_data,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_pixel_out,
  output logic       out_run_last,
  output logic       out_frame_done
);

  localparam int LINE_ROWS = 2 * MAX_RADIUS + 1;
  localparam int DEPTH     = LINE_ROWS * MAX_WIDTH;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int PROD_W    = 8 + WEIGHT_BITS;
  localparam int ACC_W     = PROD_W + 5;
  localparam int BPROD_W   = 13 + RECIP_W;

  typedef enum logic [2:0] {S_IDLE, S_WR, S_TAP, S_FLUSH, S_DIV, S_RES} st_t;

  function automatic logic [15:0] wsel(input logic [1:0] ax, input logic [1:0] ay,
                                       input logic [63:0] wn, input logic [31:0] wf);
    logic [3:0]  k;
    logic [15:0] w;
    k = {ax, ay};
    case (k) inside
      4'b0000:          w = wn[15:0];
      4'b0100, 4'b0001: w = wn[31:16];
      4'b0101:          w = wn[47:32];
      4'b1000, 4'b0010: w = wn[63:48];
      4'b1001, 4'b0110: w = wf[15:0];
      4'b1010:          w = wf[31:16];
      default:          w = '0;
    endcase
    return w;
  endfunction

  st_t                     st_r;
  q_entry_t                ent_r;
  logic [CNT_W-1:0]        kidx_r;
  logic [ROW_W-1:0]        orow_r;
  logic [COL_W-1:0]        ocol_r;
  logic [SLOT_W-1:0]       oslot_r;
  logic signed [2:0]       dy_r, dx_r;
  logic                    vld1_r, vld2_r;
  logic [WEIGHT_BITS-1:0]  w1_r;
  logic [PROD_W-1:0]       prod_r;
  logic [ACC_W-1:0]        acc_r;
  logic [12:0]             quo_r;
  logic                    out_valid_r, out_last_r, out_done_r;
  logic [7:0]              out_pix_r;

  logic signed [2:0]       rad3;
  logic signed [14:0]      ri, rh, delta;
  logic signed [12:0]      ci, cw;
  logic signed [4:0]       ds;
  logic [SLOT_W-1:0]       tap_slot;
  logic [COL_W-1:0]        tap_col;
  logic [ADDR_W-1:0]       tap_addr, wr_addr;
  logic [7:0]              rdata;
  logic [1:0]              ax, ay;
  logic [15:0]             wraw;
  logic [WEIGHT_BITS-1:0]  wtap;
  logic                    tap_last, done_pos, out_free, last_k;
  logic [ACC_W-1:0]        gsh;
  logic [BPROD_W-1:0]      bprod;
  logic [RECIP_W-1:0]      recip;

  assign rad3 = $signed({1'b0, geo.rad});

  // row mirror; only the offset from the centre row matters for the slot
  always_comb begin
    rh = $signed({2'b00, geo.height});
    ri = $signed({2'b00, orow_r}) + 15'(dy_r);
    if (ri < 0) begin
      ri = -ri;
    end
    if (ri >= rh) begin
      ri = (rh <<< 1) - 15'sd2 - ri;
    end
    delta = ri - $signed({2'b00, orow_r});
    ds = $signed({2'b00, oslot_r}) + $signed(delta[4:0]);
    if (ds < 0) begin
      ds = ds + 5'(LINE_ROWS);
    end else if (ds >= 5'(LINE_ROWS)) begin
      ds = ds - 5'(LINE_ROWS);
    end
    tap_slot = ds[SLOT_W-1:0];
  end

  always_comb begin
    cw = $signed({2'b00, geo.width});
    ci = $signed({2'b00, ocol_r}) + 13'(dx_r);
    if (ci < 0) begin
      ci = -ci;
    end
    if (ci >= cw) begin
      ci = (cw <<< 1) - 13'sd2 - ci;
    end
    tap_col = ci[COL_W-1:0];
  end

  assign tap_addr = ADDR_W'(tap_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(tap_col);
  assign wr_addr  = ADDR_W'(ent_r.slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(ent_r.col);

  mpwf_ram #(.DW(8), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (st_r == S_WR),
    .waddr (wr_addr),
    .wdata (ent_r.pix),
    .raddr (tap_addr),
    .rdata (rdata)
  );

  assign ax   = (dx_r < 0) ? 2'(-dx_r) : 2'(dx_r);
  assign ay   = (dy_r < 0) ? 2'(-dy_r) : 2'(dy_r);
  assign wraw = wsel(ax, ay, coef.wnear, coef.wfar);
  // box mode runs through the same datapath with unit weights
  assign wtap = coef.mode ? wraw[WEIGHT_BITS-1:0] : WEIGHT_BITS'(1);

  assign tap_last = (dx_r == rad3) && (dy_r == rad3);
  assign done_pos = (orow_r == geo.height - ROW_W'(1)) && (ocol_r == geo.width - COL_W'(1));
  assign out_free = !out_valid_r || out_ready;
  assign last_k   = kidx_r == (ent_r.cnt - CNT_W'(1));
  assign q_pop    = (st_r == S_IDLE) && !q_empty;

  assign gsh   = acc_r >> WEIGHT_BITS;
  assign recip = (geo.rad == RAD_W'(1)) ? RECIP_R1 : RECIP_R2;
  assign bprod = BPROD_W'(acc_r[12:0]) * BPROD_W'(recip);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      vld1_r      <= 1'b0;
      vld2_r      <= 1'b0;
      out_valid_r <= 1'b0;
      orow_r      <= '0;
      ocol_r      <= '0;
      oslot_r     <= '0;
      kidx_r      <= '0;
    end else begin
      // S_RES reloads the output register itself
      if (out_valid_r && out_ready && (st_r != S_RES)) begin
        out_valid_r <= 1'b0;
      end
      vld1_r <= (st_r == S_TAP);
      w1_r   <= wtap;
      vld2_r <= vld1_r;
      prod_r <= PROD_W'(rdata) * PROD_W'(w1_r);
      if (vld2_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
      if (restart) begin
        orow_r  <= '0;
        ocol_r  <= '0;
        oslot_r <= '0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (!q_empty) begin
            ent_r  <= q_data;
            kidx_r <= '0;
            dy_r   <= -rad3;
            dx_r   <= -rad3;
            acc_r  <= '0;
            st_r   <= q_data.wr ? S_WR : S_TAP;
          end
        end
        S_WR: begin
          st_r <= (ent_r.cnt == '0) ? S_IDLE : S_TAP;
        end
        S_TAP: begin
          if (tap_last) begin
            st_r <= S_FLUSH;
          end else if (dx_r == rad3) begin
            dx_r <= -rad3;
            dy_r <= dy_r + 3'sd1;
          end else begin
            dx_r <= dx_r + 3'sd1;
          end
        end
        S_FLUSH: begin
          if (!vld1_r && !vld2_r) begin
            st_r <= S_DIV;
          end
        end
        S_DIV: begin
          quo_r <= coef.mode ? gsh[12:0] : 13'(bprod[BPROD_W-1:RECIP_SHIFT]);
          st_r  <= S_RES;
        end
        S_RES: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_pix_r   <= (quo_r > 13'd255) ? 8'd255 : quo_r[7:0];
            out_last_r  <= last_k || done_pos;
            out_done_r  <= done_pos;
            if (done_pos) begin
              orow_r  <= '0;
              ocol_r  <= '0;
              oslot_r <= '0;
            end else if (ocol_r == geo.width - COL_W'(1)) begin
              ocol_r  <= '0;
              orow_r  <= orow_r + 1'b1;
              oslot_r <= (oslot_r == SLOT_W'(LINE_ROWS - 1)) ? '0 : oslot_r + 1'b1;
            end else begin
              ocol_r <= ocol_r + 1'b1;
            end
            if (done_pos || last_k) begin
              st_r <= S_IDLE;
            end else begin
              kidx_r <= kidx_r + 1'b1;
              dy_r   <= -rad3;
              dx_r   <= -rad3;
              acc_r  <= '0;
              st_r   <= S_TAP;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_pix_r;
  assign out_run_last   = out_last_r;
  assign out_frame_done = out_done_r;

  `MPWF_ASSERT_IMP(a_done_is_last, clk, rst_n, out_valid_r && out_done_r, out_last_r)
  `MPWF_ASSERT_NXT(a_done_wraps, clk, rst_n, (st_r == S_RES) && out_free && done_pos, (orow_r == '0) && (ocol_r == '0))
  `MPWF_ASSERT_IMP(a_pipe_in_tap, clk, rst_n, vld2_r, (st_r == S_TAP) || (st_r == S_FLUSH))

endmodule

### rtl/mirror_padded_window_filter_core.sv
// Top level of the mirror-padded 2D window filter.
//
// Input channel in_*: one request per pixel (in_cmd 0) or drain tick (in_cmd 1),
// raster order. Output channel out_*: filtered pixels in raster order; each
// output lags the input by radius rows and radius columns, drain ticks after
// the last pixel flush the final rows. out_run_last marks the last result of
// a request, out_frame_done the frame's final pixel.
// Config port cfg_*: always ready; write only while the block is idle.
// Writing radius, width or height restarts the frame.
// The engine reads the (2R+1)^2 window taps of each result through the single
// line-store read port, one window tap per cycle; a pixel at a row end can have
// further results. A pixel with no result only writes the line store.
// A four-entry queue decouples the input from the filter engine. Reset is
// synchronous; the line store keeps its contents and needs no clearing pass.
// When out_ready is low the result holds in the output register and the
// engine and then the queue back up.
module mirror_padded_window_filter_core import mpwf_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_RADIUS  = MAX_RADIUS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [7:0]  in_pixel_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_pixel_out,
  output logic        out_run_last,
  output logic        out_frame_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int RAD_MAX = (MAX_RADIUS < 2) ? MAX_RADIUS : 2;

  logic             mode_r;
  logic [RAD_W-1:0] rad_r;
  logic [COL_W-1:0] width_r;
  logic [ROW_W-1:0] height_r;
  logic [63:0]      wnear_r;
  logic [31:0]      wfar_r;

  logic     restart, cfg_we;
  geo_t     geo;
  coef_t    coef;
  logic     q_push, q_pop, q_full, q_empty;
  q_entry_t q_din, q_dout;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign restart   = cfg_we && ((cfg_index == CFG_RADIUS) || (cfg_index == CFG_WIDTH) ||
                                (cfg_index == CFG_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_RST;
      rad_r    <= RADIUS_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      wnear_r  <= WNEAR_RST;
      wfar_r   <= WFAR_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODE:   mode_r   <= cfg_data[0];
        CFG_RADIUS: rad_r    <= cfg_data[RAD_W-1:0];
        CFG_WIDTH:  width_r  <= cfg_data[COL_W-1:0];
        CFG_HEIGHT: height_r <= cfg_data[ROW_W-1:0];
        CFG_WNEAR:  wnear_r  <= cfg_data;
        CFG_WFAR:   wfar_r   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (rad_r < RAD_W'(1)) begin
      geo.rad = RAD_W'(1);
    end else if (rad_r > RAD_W'(RAD_MAX)) begin
      geo.rad = RAD_W'(RAD_MAX);
    end else begin
      geo.rad = rad_r;
    end
    if (width_r < COL_W'(MIN_SIDE)) begin
      geo.width = COL_W'(MIN_SIDE);
    end else if ({2'b00, width_r} > 13'(MAX_WIDTH)) begin
      geo.width = COL_W'(MAX_WIDTH);
    end else begin
      geo.width = width_r;
    end
    if (height_r < ROW_W'(MIN_SIDE)) begin
      geo.height = ROW_W'(MIN_SIDE);
    end else if (height_r > ROW_W'(MAX_HEIGHT)) begin
      geo.height = ROW_W'(MAX_HEIGHT);
    end else begin
      geo.height = height_r;
    end
  end

  assign coef.mode  = mode_r;
  assign coef.wnear = wnear_r;
  assign coef.wfar  = wfar_r;

  mpwf_front #(.MAX_RADIUS(MAX_RADIUS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_cmd      (in_cmd),
    .in_pixel_in (in_pixel_in),
    .geo         (geo),
    .restart     (restart),
    .q_push      (q_push),
    .q_data      (q_din),
    .q_full      (q_full)
  );

  mpwf_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  mpwf_back #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_RADIUS  (MAX_RADIUS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .geo            (geo),
    .coef           (coef),
    .restart        (restart),
    .q_empty        (q_empty),
    .q_data         (q_dout),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_out  (out_pixel_out),
    .out_run_last   (out_run_last),
    .out_frame_done (out_frame_done)
  );

endmodule

### dv/tb.sv
// Testbench for the mirror-padded window filter: random frames checked against a predictor.
`timescale 1ns / 100ps

module tb;
  import mpwf_pkg::*;

  localparam int STORE_ROWS = 5;
  localparam int STORE_COLS = 1024;
  localparam int QUIET_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 60;
  localparam logic [2:0] CFG_SPARE = 3'd6;

  typedef struct packed {
    logic [7:0] pix;
    logic       run_last;
    logic       frame_done;
  } px_result_t;

  class window_scoreboard;
    byte unsigned rows[STORE_ROWS*STORE_COLS];
    int unsigned in_row, in_col, out_row, out_col;
    logic        mode;
    logic [1:0]  radius;
    logic [10:0] width;
    logic [12:0] height;
    logic [63:0] wnear;
    logic [31:0] wfar;
    px_result_t  expected_q[$];
    int          errors;
    bit          closed;

    function void restart();
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    endfunction

    function void init();
      foreach (rows[i]) rows[i] = 0;
      restart();
      mode = MODE_RST; radius = RADIUS_RST; width = WIDTH_RST; height = HEIGHT_RST;
      wnear = WNEAR_RST; wfar = WFAR_RST;
      errors = 0;
      closed = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] data);
      case (idx)
        CFG_MODE:   mode = data[0];
        CFG_RADIUS: begin radius = data[1:0]; restart(); end
        CFG_WIDTH:  begin width = data[10:0]; restart(); end
        CFG_HEIGHT: begin height = data[12:0]; restart(); end
        CFG_WNEAR:  wnear = data;
        CFG_WFAR:   wfar = data[31:0];
        default: ;
      endcase
    endfunction

    function int reflect(int i, int n);
      if (i < 0) i = -i;
      if (i >= n) i = 2 * (n - 1) - i;
      return i;
    endfunction

    function longint unsigned tap(int d2);
      case (d2)
        0: return wnear[15:0];
        1: return wnear[31:16];
        2: return wnear[47:32];
        4: return wnear[63:48];
        5: return wfar[15:0];
        8: return wfar[31:16];
        default: return 0;
      endcase
    endfunction

    function logic [7:0] window_value(int r, int c, int rad, int w, int h);
      longint unsigned acc;
      int rr, cc;
      acc = 0;
      for (int dy = -rad; dy <= rad; dy++) begin
        rr = reflect(r + dy, h);
        for (int dx = -rad; dx <= rad; dx++) begin
          cc = reflect(c + dx, w);
          if (mode)
            acc += rows[(rr % STORE_ROWS)*STORE_COLS + cc] * tap(dx*dx + dy*dy);
          else
            acc += rows[(rr % STORE_ROWS)*STORE_COLS + cc];
        end
      end
      if (mode) acc = acc >> 16;
      else acc = acc / ((2*rad + 1) * (2*rad + 1));
      return (acc > 255) ? 8'd255 : acc[7:0];
    endfunction

    // accepted request: update state, queue the pixels it releases
    function void note_request(logic cmd, logic [7:0] pix);
      int rad, w, h, count;
      bit done;
      px_result_t res;
      rad = (radius < 1) ? 1 : (radius > 2) ? 2 : radius;
      w = (width < 5) ? 5 : (width > 1024) ? 1024 : width;
      h = (height < 5) ? 5 : (height > 4096) ? 4096 : height;
      count = 0;
      done = 0;
      if (in_row < h) begin
        if (cmd) return;
        rows[(in_row % STORE_ROWS)*STORE_COLS + in_col] = pix;
      end
      if (in_row >= rad && in_col >= rad) count = (in_col == w - 1) ? rad + 1 : 1;
      for (int k = 0; k < count; k++) begin
        done = (out_row == h - 1 && out_col == w - 1);
        res.pix = window_value(out_row, out_col, rad, w, h);
        res.run_last = (k == count - 1) || done;
        res.frame_done = done;
        expected_q.push_back(res);
        if (++out_col >= w) begin out_col = 0; out_row++; end
        if (done) break;
      end
      closed = done;
      if (done) restart();
      else if (++in_col >= w) begin in_col = 0; in_row++; end
    endfunction

    function void check_result(px_result_t got);
      px_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result pix=%0d run_last=%0b frame_done=%0b",
                 $time, got.pix, got.run_last, got.frame_done);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.pix !== exp_r.pix) begin
        $display("%0t: pixel_out expected %0d got %0d", $time, exp_r.pix, got.pix);
        errors++;
      end
      if (got.run_last !== exp_r.run_last) begin
        $display("%0t: run_last expected %0b got %0b", $time, exp_r.run_last, got.run_last);
        errors++;
      end
      if (got.frame_done !== exp_r.frame_done) begin
        $display("%0t: frame_done expected %0b got %0b", $time, exp_r.frame_done,
                 got.frame_done);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0, in_cmd = 0;
  logic [7:0]  in_pixel_in = 0;
  logic        in_ready;
  logic        out_valid, out_run_last, out_frame_done;
  logic        out_ready = 0;
  logic [7:0]  out_pixel_out;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 0;
  logic [63:0] cfg_data = 0;

  window_scoreboard sb = new();
  int idle_pct = 0, stall_pct = 0;
  int quiet = 0;
  int sent = 0;

  always #10 clk = ~clk;

  mirror_padded_window_filter_core u_top (.*);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_pixel_out, out_run_last, out_frame_done});
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || !rst_n)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("FAIL mirror_padded_window_filter_core");
      $finish;
    end
  end

  task automatic send(logic cmd, logic [7:0] pix);
    in_valid <= 1;
    in_cmd <= cmd;
    in_pixel_in <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(cmd, pix);
    sent++;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [63:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_pix();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      default: return $urandom_range(255);
    endcase
  endfunction

  // full frame, a few ignored drain ticks inside, then drain until frame end
  task automatic run_frame(int npix);
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(19) == 0) send(1'b1, $urandom_range(255));
      send(1'b0, rand_pix());
    end
    while (!sb.closed) send($urandom_range(1), $urandom_range(255));
  endtask

  task automatic set_geometry(int rad, int w, int h);
    write_cfg(CFG_RADIUS, rad);
    write_cfg(CFG_WIDTH, w);
    write_cfg(CFG_HEIGHT, h);
  endtask

  initial begin
    int w, h, rad;
    sb.init();
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // largest geometry and out-of-range values in partial frames, then full minimum-size frames
    set_geometry(3, 1024, 4096);
    for (int i = 0; i < 12; i++) send($urandom_range(1), rand_pix());
    settle();
    set_geometry(2, 2047, 8191);
    for (int i = 0; i < 6; i++) send(1'b0, rand_pix());
    settle();
    write_cfg(CFG_SPARE, {$urandom, $urandom});
    write_cfg(CFG_MODE, 0);
    set_geometry(0, 0, 0);
    run_frame(25);
    settle();
    write_cfg(CFG_MODE, 1);
    write_cfg(CFG_WNEAR, '1);
    write_cfg(CFG_WFAR, '1);
    set_geometry(2, 5, 5);
    run_frame(25);
    settle();
    write_cfg(CFG_WNEAR, '0);
    write_cfg(CFG_WFAR, '0);
    run_frame(25);
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 65; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 65; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      for (int f = 0; f < 2; f++) begin
        rad = $urandom_range(1, 2);
        w = $urandom_range(5, 7);
        h = $urandom_range(5, 6);
        write_cfg(CFG_MODE, $urandom_range(1));
        write_cfg(CFG_WNEAR, {$urandom, $urandom});
        write_cfg(CFG_WFAR, $urandom);
        set_geometry(rad, w, h);
        run_frame(w * h);
        settle();
      end
    end

    // a wide row run that ends before the row completes
    set_geometry(1, 1024, 5);
    for (int i = 0; i < 20; i++) send(1'b0, rand_pix());
    settle();

    if (sb.errors == 0)
      $display("PASS mirror_padded_window_filter_core");
    else
      $display("FAIL mirror_padded_window_filter_core");
    $finish;
  end
endmodule
